// ===== rtl/c_subset_token_scanner_core_assert.svh =====
// Assertion macros shared by the checker of the token scanner core.
`ifndef C_SUBSET_TOKEN_SCANNER_CORE_ASSERT_SVH
`define C_SUBSET_TOKEN_SCANNER_CORE_ASSERT_SVH

// Concurrent implication checked in the same cycle, disabled during reset.
`define CTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token scanner assertion failed");

// Implication checked at the following clock, disabled during reset.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token scanner assertion failed");

`endif

// ===== rtl/cts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Types, constants and keyword tables of the C-subset token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int OFFSET_BITS   = 20;
	localparam int POSITION_BITS = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int MAX_RESULTS   = 3;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_DIRECTIVE,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_TRAIL,
		MODE_STRING,
		MODE_CHAR,
		MODE_NUMBER,
		MODE_SYMBOL
	} scan_mode_t;

	typedef enum logic [3:0] {
		KIND_END,
		KIND_SYMBOL,
		KIND_SEPARATOR,
		KIND_COMMENT,
		KIND_KEYWORD,
		KIND_DIRECTIVE,
		KIND_STRING,
		KIND_CHAR,
		KIND_NUMBER
	} token_kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} src_word_t;

	typedef struct packed {
		logic [3:0]               token_kind;
		logic [3:0]               keyword_id;
		logic [OFFSET_BITS-1:0]   token_offset;
		logic [OFFSET_BITS:0]     token_length;
		logic [POSITION_BITS-1:0] token_row;
		logic [POSITION_BITS-1:0] token_column;
		logic                     run_last;
	} tok_word_t;

	typedef struct packed {
		logic [1:0]      cnt;
		tok_word_t [2:0] toks;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	localparam logic [47:0] KW_TEXT [8] = '{
		"char  ", "int   ", "float ", "void  ",
		"bool  ", "const ", "static", "inline"
	};
	localparam logic [2:0] KW_LEN [8] = '{
		3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6
	};

	function automatic logic [7:0] kw_byte(logic [2:0] k, logic [2:0] p);
		logic [47:0] w;
		w = KW_TEXT[k];
		case (p)
			3'd0: return w[47:40];
			3'd1: return w[39:32];
			3'd2: return w[31:24];
			3'd3: return w[23:16];
			3'd4: return w[15:8];
			3'd5: return w[7:0];
			default: return 8'h00;
		endcase
	endfunction

endpackage

// ===== rtl/cts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_front
// Accepts source bytes, updates the scan state and forms a bundle of the
// tokens that each byte completes.
// ----------------------------------------------------------------------------
module cts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  cts_pkg::src_word_t src_word,
	output logic               push,
	output cts_pkg::bundle_t   bundle
);

	localparam int OB = cts_pkg::OFFSET_BITS;
	localparam int PW = cts_pkg::POSITION_BITS;
	localparam int LW = OB + 2;
	localparam logic [LW-1:0] LIMIT = LW'(1) << OB;
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
	localparam logic [PW-1:0] POS_ONE = PW'(1);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	cts_pkg::scan_mode_t mode_q, m;
	logic          esc_q, esc;
	logic          star_q, star;
	logic [1:0]    ccnt_q, ccnt;
	logic          frac_q, frac;
	logic [OB:0]   boff_q, nboff, fboff;
	logic [PW-1:0] line_q, nline, fline;
	logic [PW-1:0] col_q, ncol, fcol;
	logic [OB-1:0] soff_q, soff;
	logic [PW-1:0] sline_q, sline;
	logic [PW-1:0] scol_q, scol;
	logic [7:0]    cand_q, cand;
	cts_pkg::tok_word_t [2:0] toks;
	logic [1:0]    cnt;
	logic          go;
	logic          finish;
	logic [7:0]    b;
	logic [OB:0]   p;
	cts_pkg::token_kind_t ckind;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return (c == 8'h2E) || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h28) ||
			(c == 8'h29) || (c == 8'h5B) || (c == 8'h5D) || (c == 8'h7B) ||
			(c == 8'h7D) || (c == 8'h2A) || (c == 8'h3D) || is_space(c);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [OB-1:0] sat_off(logic [OB:0] v);
		return v[OB] ? {OB{1'b1}} : v[OB-1:0];
	endfunction

	function automatic cts_pkg::tok_word_t make_tok(cts_pkg::token_kind_t kind,
		logic incl, logic [OB:0] bo, logic [OB-1:0] so, logic [PW-1:0] row,
		logic [PW-1:0] col, logic [7:0] cd);
		cts_pkg::tok_word_t t;
		logic [LW-1:0] len;
		logic [3:0]    kw;
		len = {1'b0, bo} + LW'(incl) - LW'(so);
		if (len > LIMIT) begin
			len = LIMIT;
		end
		kw = 4'd0;
		for (int k = 0; k < 8; k++) begin
			if (cd[k] && len == LW'(cts_pkg::KW_LEN[k])) begin
				kw = 4'(k + 1);
			end
		end
		t = '0;
		t.token_kind = kind;
		if (kind == cts_pkg::KIND_SYMBOL && kw != 4'd0) begin
			t.token_kind = cts_pkg::KIND_KEYWORD;
			t.keyword_id = kw;
		end
		t.token_offset = so;
		t.token_length = len[OB:0];
		t.token_row    = row;
		t.token_column = col;
		return t;
	endfunction

	always_comb begin
		b = src_word.text_byte;
		m = mode_q; esc = esc_q; star = star_q; ccnt = ccnt_q; frac = frac_q;
		soff = soff_q; sline = sline_q; scol = scol_q; cand = cand_q;
		toks = '0;
		cnt = 2'd0;
		p = '0;
		go = (b != 8'h00);
		for (int pass = 0; pass < 3; pass++) begin
			if (go) begin
				go = 1'b0;
				case (m)
					cts_pkg::MODE_IDLE: begin
						if (!is_space(b)) begin
							soff = sat_off(boff_q); sline = line_q; scol = col_q;
							esc = 1'b0; star = 1'b0; frac = 1'b0; ccnt = 2'd0;
							cand = 8'hFF;
							if (b == CH_HASH) begin
								m = cts_pkg::MODE_DIRECTIVE;
							end else if (is_sep(b)) begin
								m = cts_pkg::MODE_IDLE;
								if (cnt < 2'd3) begin
									toks[cnt] = make_tok(cts_pkg::KIND_SEPARATOR, 1'b1,
										boff_q, soff, sline, scol, cand);
									cnt = cnt + 2'd1;
								end
							end else if (b == CH_SLASH) begin
								m = cts_pkg::MODE_SLASH;
							end else if (b == CH_DQ) begin
								m = cts_pkg::MODE_STRING;
							end else if (b == CH_SQ) begin
								m = cts_pkg::MODE_CHAR;
								ccnt = 2'd3;
							end else if (is_digit(b)) begin
								m = cts_pkg::MODE_NUMBER;
							end else begin
								m = cts_pkg::MODE_SYMBOL;
								p = boff_q - {1'b0, soff};
								for (int k = 0; k < 8; k++) begin
									if (p >= (OB+1)'(cts_pkg::KW_LEN[k])) begin
										cand[k] = 1'b0;
									end else if (cts_pkg::kw_byte(3'(k), p[2:0]) != b) begin
										cand[k] = 1'b0;
									end
								end
							end
						end
					end
					cts_pkg::MODE_DIRECTIVE, cts_pkg::MODE_LINE: begin
						if (esc) begin
							esc = 1'b0;
						end else if (b == CH_NL) begin
							if (m == cts_pkg::MODE_DIRECTIVE) begin
								if (cnt < 2'd3) begin
									toks[cnt] = make_tok(cts_pkg::KIND_DIRECTIVE, 1'b0,
										boff_q, soff, sline, scol, cand);
									cnt = cnt + 2'd1;
								end
								m = cts_pkg::MODE_IDLE;
							end else begin
								m = cts_pkg::MODE_TRAIL;
							end
							go = 1'b1;
						end else if (b == CH_BSL) begin
							esc = 1'b1;
						end
					end
					cts_pkg::MODE_SLASH: begin
						if (b == CH_SLASH) begin
							m = cts_pkg::MODE_LINE;
						end else if (b == CH_STAR) begin
							m = cts_pkg::MODE_BLOCK;
							star = 1'b1;
						end else begin
							m = cts_pkg::MODE_TRAIL;
							go = 1'b1;
						end
					end
					cts_pkg::MODE_BLOCK: begin
						if (star) begin
							star = 1'b0;
							if (b == CH_SLASH) begin
								m = cts_pkg::MODE_TRAIL;
							end
						end else if (esc) begin
							esc = 1'b0;
						end else if (b == CH_BSL) begin
							esc = 1'b1;
						end else if (b == CH_STAR) begin
							star = 1'b1;
						end
					end
					cts_pkg::MODE_TRAIL: begin
						if (b == CH_SLASH) begin
							esc = 1'b0;
							m = cts_pkg::MODE_SLASH;
						end else if (!is_space(b)) begin
							if (cnt < 2'd3) begin
								toks[cnt] = make_tok(cts_pkg::KIND_COMMENT, 1'b0,
									boff_q, soff, sline, scol, cand);
								cnt = cnt + 2'd1;
							end
							m = cts_pkg::MODE_IDLE;
							go = 1'b1;
						end
					end
					cts_pkg::MODE_STRING: begin
						if (esc) begin
							esc = 1'b0;
						end else if (b == CH_DQ) begin
							if (cnt < 2'd3) begin
								toks[cnt] = make_tok(cts_pkg::KIND_STRING, 1'b1,
									boff_q, soff, sline, scol, cand);
								cnt = cnt + 2'd1;
							end
							m = cts_pkg::MODE_IDLE;
						end else if (b == CH_BSL) begin
							esc = 1'b1;
						end
					end
					cts_pkg::MODE_CHAR: begin
						if (ccnt == 2'd3) begin
							ccnt = (b == CH_BSL) ? 2'd2 : 2'd1;
						end else if (ccnt <= 2'd1) begin
							if (cnt < 2'd3) begin
								toks[cnt] = make_tok(cts_pkg::KIND_CHAR, 1'b1,
									boff_q, soff, sline, scol, cand);
								cnt = cnt + 2'd1;
							end
							m = cts_pkg::MODE_IDLE;
							ccnt = 2'd0;
						end else begin
							ccnt = ccnt - 2'd1;
						end
					end
					cts_pkg::MODE_NUMBER: begin
						if (is_digit(b)) begin
						end else if (b == CH_DOT && !frac) begin
							frac = 1'b1;
						end else begin
							if (cnt < 2'd3) begin
								toks[cnt] = make_tok(cts_pkg::KIND_NUMBER, 1'b0,
									boff_q, soff, sline, scol, cand);
								cnt = cnt + 2'd1;
							end
							m = cts_pkg::MODE_IDLE;
							go = 1'b1;
						end
					end
					cts_pkg::MODE_SYMBOL: begin
						if (is_sep(b)) begin
							if (cnt < 2'd3) begin
								toks[cnt] = make_tok(cts_pkg::KIND_SYMBOL, 1'b0,
									boff_q, soff, sline, scol, cand);
								cnt = cnt + 2'd1;
							end
							m = cts_pkg::MODE_IDLE;
							go = 1'b1;
						end else begin
							p = boff_q - {1'b0, soff};
							for (int k = 0; k < 8; k++) begin
								if (p >= (OB+1)'(cts_pkg::KW_LEN[k])) begin
									cand[k] = 1'b0;
								end else if (cts_pkg::kw_byte(3'(k), p[2:0]) != b) begin
									cand[k] = 1'b0;
								end
							end
						end
					end
					default: begin
						m = cts_pkg::MODE_IDLE;
						go = 1'b1;
					end
				endcase
			end
		end

		nboff = boff_q[OB] ? boff_q : boff_q + (OB+1)'(1);
		if (b == CH_NL) begin
			nline = (line_q < POS_MAX) ? line_q + POS_ONE : line_q;
			ncol  = POS_ONE;
		end else begin
			nline = line_q;
			ncol  = (col_q < POS_MAX) ? col_q + POS_ONE : col_q;
		end

		finish = (b == 8'h00) || src_word.end_of_text;
		if (b == 8'h00) begin
			fboff = boff_q; fline = line_q; fcol = col_q;
		end else begin
			fboff = nboff; fline = nline; fcol = ncol;
		end

		case (m)
			cts_pkg::MODE_DIRECTIVE: ckind = cts_pkg::KIND_DIRECTIVE;
			cts_pkg::MODE_SLASH, cts_pkg::MODE_LINE, cts_pkg::MODE_BLOCK,
			cts_pkg::MODE_TRAIL: ckind = cts_pkg::KIND_COMMENT;
			cts_pkg::MODE_STRING: ckind = cts_pkg::KIND_STRING;
			cts_pkg::MODE_CHAR: ckind = cts_pkg::KIND_CHAR;
			cts_pkg::MODE_NUMBER: ckind = cts_pkg::KIND_NUMBER;
			cts_pkg::MODE_SYMBOL: ckind = cts_pkg::KIND_SYMBOL;
			default: ckind = cts_pkg::KIND_END;
		endcase

		if (finish) begin
			if (m != cts_pkg::MODE_IDLE && cnt < 2'd3) begin
				toks[cnt] = make_tok(ckind, 1'b0, fboff, soff, sline, scol, cand);
				cnt = cnt + 2'd1;
			end
			if (cnt < 2'd3) begin
				toks[cnt] = '0;
				toks[cnt].token_kind   = cts_pkg::KIND_END;
				toks[cnt].token_offset = sat_off(fboff);
				toks[cnt].token_row    = fline;
				toks[cnt].token_column = fcol;
				cnt = cnt + 2'd1;
			end
		end
	end

	always_comb begin
		push        = accept && (cnt != 2'd0);
		bundle.cnt  = cnt;
		bundle.toks = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cts_pkg::MODE_IDLE;
			esc_q   <= 1'b0;
			star_q  <= 1'b0;
			ccnt_q  <= 2'd0;
			frac_q  <= 1'b0;
			boff_q  <= '0;
			line_q  <= POS_ONE;
			col_q   <= POS_ONE;
			soff_q  <= '0;
			sline_q <= POS_ONE;
			scol_q  <= POS_ONE;
			cand_q  <= 8'hFF;
		end else if (accept) begin
			if (finish) begin
				mode_q  <= cts_pkg::MODE_IDLE;
				esc_q   <= 1'b0;
				star_q  <= 1'b0;
				ccnt_q  <= 2'd0;
				frac_q  <= 1'b0;
				boff_q  <= '0;
				line_q  <= POS_ONE;
				col_q   <= POS_ONE;
				soff_q  <= '0;
				sline_q <= POS_ONE;
				scol_q  <= POS_ONE;
				cand_q  <= 8'hFF;
			end else begin
				mode_q  <= m;
				esc_q   <= esc;
				star_q  <= star;
				ccnt_q  <= ccnt;
				frac_q  <= frac;
				boff_q  <= nboff;
				line_q  <= nline;
				col_q   <= ncol;
				soff_q  <= soff;
				sline_q <= sline;
				scol_q  <= scol;
				cand_q  <= cand;
			end
		end
	end

endmodule

// ===== rtl/cts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_queue
// Short register queue of token bundles between the front and back parts.
// ----------------------------------------------------------------------------
module cts_queue #(
	parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cts_pkg::bundle_t       push_data,
	input  logic                   pop,
	output cts_pkg::bundle_t       head,
	output cts_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cts_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign head             = mem_q[rd_q];
	assign status.full      = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/cts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_back
// Unpacks queued bundles into single output words through an output register.
// ----------------------------------------------------------------------------
module cts_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cts_pkg::bundle_t       head,
	input  cts_pkg::queue_status_t status,
	output logic                   pop,
	input  logic                   tok_stall,
	output logic                   tok_valid,
	output cts_pkg::tok_word_t     tok_word
);

	logic [1:0]         idx_q;
	logic               valid_q;
	cts_pkg::tok_word_t word_q;
	cts_pkg::tok_word_t next_word;
	logic               load;
	logic               at_end;

	assign load      = status.not_empty && (!valid_q || !tok_stall);
	assign at_end    = (idx_q == head.cnt - 2'd1);
	assign pop       = load && at_end;
	assign tok_valid = valid_q;
	assign tok_word  = word_q;

	always_comb begin
		next_word          = head.toks[idx_q];
		next_word.run_last = at_end;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!tok_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/c_subset_token_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_core
// Splits a C-subset source byte stream into tokens.
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle while the bundle queue has room. Each
// byte yields zero to three token words, which leave one per cycle from the
// output register while tok_stall is low, so sustained throughput is one byte
// per cycle until the token count exceeds the byte count, and then one token
// word per cycle. The first token word of a byte passes through the bundle
// queue and the output register before it appears on the output.
module c_subset_token_scanner_core #(
	parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  cts_pkg::src_word_t src_word,
	output logic               tok_valid,
	input  logic               tok_stall,
	output cts_pkg::tok_word_t tok_word
);

	logic                   push;
	logic                   pop;
	cts_pkg::bundle_t       bundle;
	cts_pkg::bundle_t       head;
	cts_pkg::queue_status_t status;

	assign src_stall = status.full;

	cts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (src_valid && !src_stall),
		.src_word (src_word),
		.push     (push),
		.bundle   (bundle)
	);

	cts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	cts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.tok_stall (tok_stall),
		.tok_valid (tok_valid),
		.tok_word  (tok_word)
	);

endmodule

// ===== rtl/cts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the token scanner core, bound to the top level.
// ----------------------------------------------------------------------------
`include "c_subset_token_scanner_core_assert.svh"

module cts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               tok_valid,
	input logic               tok_stall,
	input cts_pkg::tok_word_t tok_word
);

	`CTS_ASSERT_NEXT(a_stall_hold, clk, arst_n, tok_valid && tok_stall, tok_valid && $stable(tok_word))
	`CTS_ASSERT_IMPLY(a_kw_kind, clk, arst_n, tok_valid, (tok_word.token_kind == cts_pkg::KIND_KEYWORD) == (tok_word.keyword_id != 4'd0))
	`CTS_ASSERT_IMPLY(a_end_word, clk, arst_n, tok_valid && tok_word.token_kind == cts_pkg::KIND_END, tok_word.token_length == '0 && tok_word.run_last)
	`CTS_ASSERT_IMPLY(a_position, clk, arst_n, tok_valid, tok_word.token_row != '0 && tok_word.token_column != '0)

endmodule

bind c_subset_token_scanner_core cts_checker u_cts_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C-subset token scanner core. A queue of source
// words feeds a random-gap driver; a monitor with random stalls compares every
// token word against a scanner model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int     OB      = cts_pkg::OFFSET_BITS;
	localparam int     PB      = cts_pkg::POSITION_BITS;
	localparam longint OFF_LIM = 64'd1 << OB;
	localparam longint POS_TOP = (64'd1 << PB) - 1;

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	cts_pkg::src_word_t src_word;
	logic               tok_valid;
	logic               tok_stall;
	cts_pkg::tok_word_t tok_word;

	c_subset_token_scanner_core dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_word(tok_word)
	);

	cts_pkg::src_word_t pending_src[$];
	cts_pkg::tok_word_t expected_toks[$];
	int                 errors;
	int                 tok_count;
	int                 byte_count;
	bit                 hold_src;
	bit                 src_taken;

	cts_pkg::scan_mode_t mode;
	bit         esc, star, frac;
	logic [1:0] char_cnt;
	longint     pos, line_no, col_no, tok_start, tok_line, tok_col;
	logic [7:0] cand;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_ws(logic [7:0] b);
		return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic bit is_sep(logic [7:0] b);
		return is_ws(b) || b == "." || b == "," || b == ";" || b == "(" || b == ")" ||
			b == "[" || b == "]" || b == "{" || b == "}" || b == "*" || b == "=";
	endfunction

	function automatic bit is_dig(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic int kw_length(int k);
		int lens[8] = '{4, 3, 5, 4, 4, 5, 6, 6};
		return lens[k];
	endfunction

	function automatic logic [7:0] kw_char(int k, longint p);
		string words[8] = '{"char", "int", "float", "void", "bool", "const", "static",
			"inline"};
		if (p >= words[k].len())
			return 8'h00;
		return words[k][p];
	endfunction

	task automatic clear_scanner();
		mode = cts_pkg::MODE_IDLE;
		esc = 0; star = 0; frac = 0; char_cnt = 2'd0;
		pos = 0; line_no = 1; col_no = 1;
		tok_start = 0; tok_line = 1; tok_col = 1;
		cand = 8'hFF;
	endtask

	task automatic push_tok(cts_pkg::token_kind_t kind, int kw, longint off, longint len,
		longint row, longint col);
		cts_pkg::tok_word_t t;
		t.token_kind = kind;
		t.keyword_id = 4'(kw);
		t.token_offset = OB'(off);
		t.token_length = (OB+1)'(len);
		t.token_row = PB'(row);
		t.token_column = PB'(col);
		t.run_last = 1'b0;
		expected_toks.push_back(t);
	endtask

	task automatic finish_tok(cts_pkg::token_kind_t kind, int incl);
		longint len;
		int kw;
		len = pos + incl - tok_start;
		kw = 0;
		if (len > OFF_LIM)
			len = OFF_LIM;
		if (kind == cts_pkg::KIND_SYMBOL) begin
			for (int k = 0; k < 8; k++)
				if (cand[k] && kw_length(k) == len)
					kw = k + 1;
			if (kw != 0)
				kind = cts_pkg::KIND_KEYWORD;
		end
		push_tok(kind, kw, tok_start, len, tok_line, tok_col);
	endtask

	task automatic open_tok(cts_pkg::scan_mode_t m);
		tok_start = pos < OFF_LIM ? pos : OFF_LIM - 1;
		tok_line = line_no;
		tok_col = col_no;
		mode = m;
		esc = 0; star = 0; frac = 0; char_cnt = 2'd0;
		cand = 8'hFF;
	endtask

	task automatic match_kw(logic [7:0] b);
		for (int k = 0; k < 8; k++)
			if ((pos - tok_start) >= kw_length(k) || kw_char(k, pos - tok_start) != b)
				cand[k] = 1'b0;
	endtask

	task automatic end_text();
		case (mode)
			cts_pkg::MODE_DIRECTIVE: finish_tok(cts_pkg::KIND_DIRECTIVE, 0);
			cts_pkg::MODE_SLASH, cts_pkg::MODE_LINE, cts_pkg::MODE_BLOCK,
			cts_pkg::MODE_TRAIL: finish_tok(cts_pkg::KIND_COMMENT, 0);
			cts_pkg::MODE_STRING: finish_tok(cts_pkg::KIND_STRING, 0);
			cts_pkg::MODE_CHAR: finish_tok(cts_pkg::KIND_CHAR, 0);
			cts_pkg::MODE_NUMBER: finish_tok(cts_pkg::KIND_NUMBER, 0);
			cts_pkg::MODE_SYMBOL: finish_tok(cts_pkg::KIND_SYMBOL, 0);
			default: ;
		endcase
		push_tok(cts_pkg::KIND_END, 0, pos < OFF_LIM ? pos : OFF_LIM - 1, 0, line_no,
			col_no);
		clear_scanner();
	endtask

	task automatic scan_byte(cts_pkg::src_word_t w);
		logic [7:0] b;
		bit again;
		int before_n;
		b = w.text_byte;
		before_n = expected_toks.size();
		if (b == 8'h00) begin
			end_text();
		end else begin
			do begin
				again = 0;
				case (mode)
					cts_pkg::MODE_IDLE: begin
						if (is_ws(b)) begin
						end else if (b == "#") open_tok(cts_pkg::MODE_DIRECTIVE);
						else if (is_sep(b)) begin
							open_tok(cts_pkg::MODE_IDLE);
							finish_tok(cts_pkg::KIND_SEPARATOR, 1);
						end else if (b == "/") open_tok(cts_pkg::MODE_SLASH);
						else if (b == "\"") open_tok(cts_pkg::MODE_STRING);
						else if (b == "'") begin
							open_tok(cts_pkg::MODE_CHAR);
							char_cnt = 2'd3;
						end else if (is_dig(b)) open_tok(cts_pkg::MODE_NUMBER);
						else begin
							open_tok(cts_pkg::MODE_SYMBOL);
							match_kw(b);
						end
					end
					cts_pkg::MODE_DIRECTIVE, cts_pkg::MODE_LINE: begin
						if (esc) esc = 0;
						else if (b == 8'h0A) begin
							if (mode == cts_pkg::MODE_DIRECTIVE) begin
								finish_tok(cts_pkg::KIND_DIRECTIVE, 0);
								mode = cts_pkg::MODE_IDLE;
							end else
								mode = cts_pkg::MODE_TRAIL;
							again = 1;
						end else if (b == "\\") esc = 1;
					end
					cts_pkg::MODE_SLASH: begin
						if (b == "/") mode = cts_pkg::MODE_LINE;
						else if (b == "*") begin
							mode = cts_pkg::MODE_BLOCK;
							star = 1;
						end else begin
							mode = cts_pkg::MODE_TRAIL;
							again = 1;
						end
					end
					cts_pkg::MODE_BLOCK: begin
						if (star) begin
							star = 0;
							if (b == "/") mode = cts_pkg::MODE_TRAIL;
						end else if (esc) esc = 0;
						else if (b == "\\") esc = 1;
						else if (b == "*") star = 1;
					end
					cts_pkg::MODE_TRAIL: begin
						if (b == "/") begin
							esc = 0;
							mode = cts_pkg::MODE_SLASH;
						end else if (!is_ws(b)) begin
							finish_tok(cts_pkg::KIND_COMMENT, 0);
							mode = cts_pkg::MODE_IDLE;
							again = 1;
						end
					end
					cts_pkg::MODE_STRING: begin
						if (esc) esc = 0;
						else if (b == "\"") begin
							finish_tok(cts_pkg::KIND_STRING, 1);
							mode = cts_pkg::MODE_IDLE;
						end else if (b == "\\") esc = 1;
					end
					cts_pkg::MODE_CHAR: begin
						if (char_cnt == 2'd3) char_cnt = (b == "\\") ? 2'd2 : 2'd1;
						else if (char_cnt <= 2'd1) begin
							finish_tok(cts_pkg::KIND_CHAR, 1);
							mode = cts_pkg::MODE_IDLE;
							char_cnt = 2'd0;
						end else char_cnt = char_cnt - 2'd1;
					end
					cts_pkg::MODE_NUMBER: begin
						if (is_dig(b)) begin
						end else if (b == "." && !frac) frac = 1;
						else begin
							finish_tok(cts_pkg::KIND_NUMBER, 0);
							mode = cts_pkg::MODE_IDLE;
							again = 1;
						end
					end
					cts_pkg::MODE_SYMBOL: begin
						if (is_sep(b)) begin
							finish_tok(cts_pkg::KIND_SYMBOL, 0);
							mode = cts_pkg::MODE_IDLE;
							again = 1;
						end else match_kw(b);
					end
					default: begin
						mode = cts_pkg::MODE_IDLE;
						again = 1;
					end
				endcase
			end while (again);
			if (pos < OFF_LIM) pos++;
			if (b == 8'h0A) begin
				if (line_no < POS_TOP) line_no++;
				col_no = 1;
			end else if (col_no < POS_TOP) col_no++;
			if (w.end_of_text) end_text();
		end
		if (expected_toks.size() > before_n)
			expected_toks[$].run_last = 1'b1;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH token %0d %s: got %0h expected %0h", tok_count, what, got, want);
	endtask

	task automatic add_text(string s, bit mark_last);
		cts_pkg::src_word_t w;
		for (int i = 0; i < s.len(); i++) begin
			w.text_byte = s[i];
			w.end_of_text = mark_last && i == s.len() - 1;
			pending_src.push_back(w);
		end
	endtask

	function automatic string random_piece();
		string frags[24] = '{"char", "int", "float", "void", "bool", "const", "static",
			"inline", "x", "inlinex", "in", "12", "3.14", "7..", "\"a\\\"b\"",
			"'a'", "'\\n'", "#def \\\n x\n", "// c\\\n d\n", "/* a * b \\* */ ",
			"/*/", "/ ", ";", "= ( ) [ ] { } , ."};
		string s;
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) s = frags[$urandom_range(0, 23)];
		else begin
			s = "";
			for (int i = 0; i < $urandom_range(1, 4); i++)
				s = {s, string'(byte'($urandom_range(1, 255)))};
		end
		r = $urandom_range(0, 3);
		if (r == 0) s = {s, " "};
		else if (r == 1) s = {s, "\n"};
		else if (r == 2) s = {s, "\t"};
		return s;
	endfunction

	always @(posedge clk) begin
		src_taken <= arst_n && src_valid && !src_stall;
	end

	always @(negedge clk) begin
		static int src_gap = 0;
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_taken) begin
			if (src_valid) begin
				scan_byte(src_word);
				byte_count++;
				pending_src.pop_front();
				src_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
			end
			if (src_gap > 0) begin
				src_gap--;
				src_valid <= 1'b0;
			end else if (pending_src.size() > 0 && !hold_src) begin
				src_valid <= 1'b1;
				src_word <= pending_src[0];
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cts_pkg::tok_word_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_toks.size() == 0) begin
				report("unexpected word", 64'(tok_word.token_kind), 64'd0);
			end else begin
				want = expected_toks.pop_front();
				if (tok_word.token_kind !== want.token_kind)
					report("kind", 64'(tok_word.token_kind), 64'(want.token_kind));
				if (tok_word.keyword_id !== want.keyword_id)
					report("keyword", 64'(tok_word.keyword_id), 64'(want.keyword_id));
				if (tok_word.token_offset !== want.token_offset)
					report("offset", 64'(tok_word.token_offset), 64'(want.token_offset));
				if (tok_word.token_length !== want.token_length)
					report("length", 64'(tok_word.token_length), 64'(want.token_length));
				if (tok_word.token_row !== want.token_row)
					report("row", 64'(tok_word.token_row), 64'(want.token_row));
				if (tok_word.token_column !== want.token_column)
					report("column", 64'(tok_word.token_column), 64'(want.token_column));
				if (tok_word.run_last !== want.run_last)
					report("run_last", 64'(tok_word.run_last), 64'(want.run_last));
			end
			tok_count++;
		end
	end

	always @(negedge clk) begin
		static int sink_gap = 0;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			tok_stall <= 1'b1;
		end else if (tok_valid && !tok_stall && $urandom_range(0, 3) == 0) begin
			sink_gap = $urandom_range(0, 15);
			tok_stall <= sink_gap > 0;
		end else begin
			tok_stall <= 1'b0;
		end
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		cts_pkg::src_word_t w;
		errors = 0; tok_count = 0; byte_count = 0;
		hold_src = 0;
		clear_scanner();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_text("  char int float void bool const static inline charx\n", 0);
		add_text("#x \\\ny\n/*/ /* a*b\\*/ */ // l\n / x", 0);
		add_text("\"s\\\"q\" 'a' '\\n' 12.5.3 ;,.()[]{}*=", 0);
		w.text_byte = 8'hFF; w.end_of_text = 1'b0; pending_src.push_back(w);
		w.text_byte = 8'h00; pending_src.push_back(w);
		add_text("\"open", 1);
		add_text("/* unterminated", 1);

		while (pending_src.size() > 0 || expected_toks.size() > 0) @(posedge clk);
		hold_src = 1;
		repeat (20) @(posedge clk);
		hold_src = 0;

		while (byte_count < 300) begin
			if (pending_src.size() < 8) begin
				add_text(random_piece(), $urandom_range(0, 30) == 0);
				if ($urandom_range(0, 40) == 0) begin
					w.text_byte = 8'h00;
					w.end_of_text = 1'($urandom_range(0, 1));
					pending_src.push_back(w);
				end
			end
			@(posedge clk);
		end
		w.text_byte = 8'h00; w.end_of_text = 1'b1;
		pending_src.push_back(w);

		while (pending_src.size() > 0 || src_valid || expected_toks.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		$display("Scanned %0d source bytes into %0d token words, including keywords,",
			byte_count, tok_count);
		$display("directives, comments, literals, end markers and random bytes.");
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

// ===== c_subset_token_scanner_core.f =====
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_front.sv
rtl/cts_queue.sv
rtl/cts_back.sv
rtl/c_subset_token_scanner_core.sv
rtl/cts_checker.sv
sim/tb_top.sv
